>>> design/etf_pkg.sv
// Package for the Euler trail finder: sizes, codes and controller states.
// No dependencies; used by every module of the block but etf_ram.
`default_nettype none
package etf_pkg;
	localparam int MaxVertices = 8;
	localparam int VtxW        = 3;
	localparam int CntW        = 4;
	localparam int StoreDepth  = MaxVertices * (MaxVertices + 1) / 2 + 1;
	localparam int PtrW        = 6;

	localparam logic [1:0] VerdNotConn  = 2'd0;
	localparam logic [1:0] VerdNotEuler = 2'd1;
	localparam logic [1:0] VerdTrail    = 2'd2;
	localparam logic [1:0] VerdCircuit  = 2'd3;

	localparam logic KindVerdict = 1'b0;
	localparam logic KindTrail   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMPTY,
		ST_REACH,
		ST_DEG,
		ST_WALK,
		ST_WALK_RD,
		ST_VERDICT,
		ST_OUT_RD,
		ST_OUT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // write one edge bit pair
		logic clr_scan;   // reset scan index and flags
		logic scan_empty; // check one row for no edge
		logic reach_step; // one flood pass over all reached rows
		logic deg_step;   // accumulate parity of one row
		logic walk_init;  // push start vertex
		logic walk_step;  // one Hierholzer step, top is valid
		logic out_init;   // start reading trail back
		logic out_rd;     // issue read of next trail entry
		logic emit_verd;  // drive verdict word
		logic emit_trail; // drive trail word
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_done;
		logic empty_found;
		logic reach_grew;
		logic reach_full;
		logic bad_parity;
		logic stack_empty;
		logic out_done;
	} stat_t;
endpackage
`default_nettype wire

>>> design/etf_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module etf_ram #(
	parameter int Width = 3,
	parameter int Depth = 37,
	parameter int AddrW = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> design/etf_ctrl.sv
// Controller state machine of the Euler trail finder.
// Depends on etf_pkg.
`default_nettype none
module etf_ctrl import etf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic  req_type,
	input  stat_t      st,
	output cmd_t       cmd,
	output logic       busy
);
	state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && req_type) state_d = ST_EMPTY;
			end
			ST_EMPTY: begin
				if (st.empty_found) state_d = ST_VERDICT;
				else if (st.scan_done) state_d = ST_REACH;
			end
			ST_REACH: begin
				if (!st.reach_grew) begin
					state_d = st.reach_full ? ST_DEG : ST_VERDICT;
				end
			end
			ST_DEG: begin
				if (st.scan_done) state_d = st.bad_parity ? ST_VERDICT : ST_WALK_RD;
			end
			ST_WALK_RD: state_d = ST_WALK;
			ST_WALK: begin
				state_d = ST_WALK_RD;
				if (st.stack_empty) state_d = ST_VERDICT;
			end
			ST_VERDICT: begin
				if (st.out_done) state_d = ST_IDLE;
				else state_d = ST_OUT_RD;
			end
			ST_OUT_RD: state_d = ST_OUT;
			ST_OUT: begin
				if (st.out_done) state_d = ST_IDLE;
				else state_d = ST_OUT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load     = start && !req_type;
				cmd.clr_scan = start && req_type;
			end
			ST_EMPTY: begin
				cmd.scan_empty = 1'b1;
				if (st.scan_done && !st.empty_found) cmd.clr_scan = 1'b1;
			end
			ST_REACH: begin
				cmd.reach_step = 1'b1;
				if (!st.reach_grew) cmd.clr_scan = 1'b1;
			end
			ST_DEG: begin
				cmd.deg_step  = 1'b1;
				cmd.walk_init = st.scan_done && !st.bad_parity;
			end
			ST_WALK_RD: ;
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.out_init  = st.stack_empty;
			end
			ST_VERDICT: cmd.emit_verd = 1'b1;
			ST_OUT_RD: cmd.out_rd = 1'b1;
			ST_OUT: cmd.emit_trail = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> design/etf_dp.sv
// Datapath of the Euler trail finder: edge matrix, scans, walk stack, trail store.
// Depends on etf_pkg and etf_ram.
`default_nettype none
module etf_dp import etf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [CntW-1:0] cfg_wdata,
	input  wire logic [VtxW-1:0] row_vertex,
	input  wire logic [VtxW-1:0] col_vertex,
	input  wire logic            edge_bit,
	input  cmd_t                 cmd,
	output stat_t                st,
	output logic                 result_valid,
	output logic                 item_kind,
	output logic [1:0]           verdict,
	output logic [VtxW-1:0]      trail_vertex,
	output logic                 last
);
	localparam int Mv = MaxVertices;

	logic [Mv-1:0]   mat_q [Mv];
	logic [CntW-1:0] vcount_q;
	logic [VtxW-1:0] idx_q;
	logic [Mv-1:0]   reach_q;
	logic            par_q;
	logic [1:0]      odd_q;
	logic [VtxW-1:0] start_q;
	logic [1:0]      verd_q;
	logic [PtrW-1:0] sp_q, tp_q, op_q;
	logic            fail_q;

	logic [Mv-1:0]   mask;
	logic [CntW-1:0] n_act;
	logic            idx_last;
	logic [Mv-1:0]   row_m;
	logic [Mv-1:0]   reach_nx;
	logic            odd_row;
	logic [2:0]      odd_tot;
	logic [VtxW-1:0] lo_j;
	logic [VtxW-1:0] stk_rd, trl_rd;
	logic            stk_we, trl_we;
	logic [PtrW-1:0] stk_wa, stk_ra;
	logic [VtxW-1:0] stk_wd;

	// Active vertex count and mask
	always_comb begin
		n_act = vcount_q;
		if (vcount_q == '0) n_act = CntW'(1);
		if (vcount_q > CntW'(Mv)) n_act = CntW'(Mv);
		for (int i = 0; i < Mv; i++) mask[i] = (CntW'(i) < n_act);
		idx_last = ({1'b0, idx_q} == n_act - CntW'(1));
		row_m    = mat_q[idx_q] & mask;
		odd_row  = ^(row_m & ~(Mv'(1) << idx_q));
		odd_tot  = {1'b0, odd_q} + 3'(odd_row);
		reach_nx = reach_q;
		for (int i = 0; i < Mv; i++) begin
			if (reach_q[i]) reach_nx = reach_nx | (mat_q[i] & mask);
		end
	end

	// Lowest neighbor of the stack top
	always_comb begin
		lo_j = '0;
		for (int j = Mv - 1; j >= 0; j--) begin
			if (mat_q[stk_rd][j] && mask[j]) lo_j = VtxW'(j);
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= CntW'(4);
		else if (cfg_we) vcount_q <= cfg_wdata;
	end

	// Edge matrix: load and consume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Mv; i++) mat_q[i] <= '0;
		end else if (cmd.load) begin
			mat_q[row_vertex][col_vertex] <= edge_bit;
			mat_q[col_vertex][row_vertex] <= edge_bit;
		end else if (cmd.walk_step && (mat_q[stk_rd] & mask) != '0) begin
			mat_q[stk_rd][lo_j] <= 1'b0;
			mat_q[lo_j][stk_rd] <= 1'b0;
		end
	end

	// Scan counters, flags and walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; reach_q <= '0; par_q <= 1'b0; odd_q <= '0;
			start_q <= '0; verd_q <= VerdNotConn; sp_q <= '0; tp_q <= '0;
			op_q <= '0; fail_q <= 1'b0;
		end else begin
			if (cmd.clr_scan) begin
				idx_q   <= '0;
				reach_q <= Mv'(1);
				odd_q   <= '0;
				start_q <= '0;
				verd_q  <= VerdNotConn;
				fail_q  <= 1'b0;
				tp_q    <= '0;
			end else if (cmd.scan_empty) begin
				if (row_m == '0) fail_q <= 1'b1;
				idx_q <= idx_q + VtxW'(1);
			end else if (cmd.deg_step) begin
				idx_q <= idx_q + VtxW'(1);
				if (odd_row) begin
					if (odd_q == 2'd0) start_q <= idx_q;
					if (odd_q != 2'd3) odd_q <= odd_q + 2'd1;
				end
			end
			if (cmd.reach_step) begin
				reach_q <= reach_nx;
				if (reach_nx == reach_q && (reach_q & mask) != mask) verd_q <= VerdNotConn;
			end
			if (cmd.deg_step && idx_last) begin
				if (st.bad_parity) verd_q <= VerdNotEuler;
				else if (odd_q != 2'd0 || odd_row) verd_q <= VerdTrail;
				else verd_q <= VerdCircuit;
			end
			if (cmd.walk_init) begin
				sp_q <= PtrW'(1);
			end
			if (cmd.walk_step) begin
				if ((mat_q[stk_rd] & mask) != '0) begin
					if (sp_q < PtrW'(StoreDepth)) sp_q <= sp_q + PtrW'(1);
				end else begin
					sp_q <= sp_q - PtrW'(1);
					if (tp_q < PtrW'(StoreDepth)) tp_q <= tp_q + PtrW'(1);
				end
			end
			// Final pop writes one more trail entry in the same cycle
			if (cmd.out_init) op_q <= tp_q + PtrW'(1);
			if (cmd.out_rd) op_q <= op_q - PtrW'(1);
		end
	end

	// Walk stack: write on push, read top
	always_comb begin
		stk_we = 1'b0;
		stk_wa = '0;
		stk_wd = '0;
		if (cmd.walk_init) begin
			stk_we = 1'b1;
			stk_wd = (odd_q != 2'd0) ? start_q : (odd_row ? idx_q : '0);
		end else if (cmd.walk_step && (mat_q[stk_rd] & mask) != '0
			&& sp_q < PtrW'(StoreDepth)) begin
			stk_we = 1'b1;
			stk_wa = sp_q;
			stk_wd = lo_j;
		end
		stk_ra = (sp_q == '0) ? '0 : sp_q - PtrW'(1);
		trl_we = cmd.walk_step && (mat_q[stk_rd] & mask) == '0
			&& tp_q < PtrW'(StoreDepth);
	end

	etf_ram #(.Width(VtxW), .Depth(StoreDepth), .AddrW(PtrW)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd)
	);

	etf_ram #(.Width(VtxW), .Depth(StoreDepth), .AddrW(PtrW)) u_trail (
		.clk(clk), .we(trl_we), .waddr(tp_q), .wdata(stk_rd),
		.raddr(op_q - PtrW'(1)), .rdata(trl_rd)
	);

	// Status to controller
	always_comb begin
		st.scan_done   = idx_last;
		st.empty_found = cmd.scan_empty && (fail_q || row_m == '0) && idx_last
			|| cmd.scan_empty && row_m == '0;
		st.reach_grew  = (reach_nx != reach_q);
		st.reach_full  = ((reach_q & mask) == mask);
		// Saturated odd count of 3 gives a total of 3 or 4, both rejected
		st.bad_parity  = idx_last && !(odd_tot == 3'd0 || odd_tot == 3'd2);
		st.stack_empty = cmd.walk_step && (mat_q[stk_rd] & mask) == '0
			&& sp_q == PtrW'(1);
		st.out_done    = (op_q == '0) || (verd_q == VerdNotConn)
			|| (verd_q == VerdNotEuler);
	end

	// Result word
	always_comb begin
		result_valid = cmd.emit_verd || cmd.emit_trail;
		item_kind    = cmd.emit_trail ? KindTrail : KindVerdict;
		verdict      = verd_q;
		trail_vertex = cmd.emit_trail ? trl_rd : '0;
		last         = cmd.emit_trail ? (op_q == '0) : st.out_done;
	end
endmodule
`default_nettype wire

>>> design/euler_trail_finder.sv
// Euler trail finder: an edge load is taken while idle; a run scans the rows for empty
// rows, makes reach passes, scans the degrees, and for a trail or circuit walks with a
// registered stack read before each step; it gives a verdict word, then the trail words.
// A load gives no word; a run gives a verdict word and any trail words; busy stays high during a run.
// Reset clears the edge matrix and sets vertex_count to 4; results cannot be stalled.
// Depends on etf_pkg, etf_ctrl, etf_dp.
`default_nettype none
module euler_trail_finder import etf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic            cfg_we,
	input  wire logic [CntW-1:0] cfg_wdata,
	input  wire logic            req_type,
	input  wire logic [VtxW-1:0] row_vertex,
	input  wire logic [VtxW-1:0] col_vertex,
	input  wire logic            edge_bit,
	output logic                 result_valid,
	output logic                 item_kind,
	output logic [1:0]           verdict,
	output logic [VtxW-1:0]      trail_vertex,
	output logic                 last
);
	cmd_t  cmd;
	stat_t st;

	etf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.st(st), .cmd(cmd), .busy(busy)
	);

	etf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.row_vertex(row_vertex), .col_vertex(col_vertex), .edge_bit(edge_bit),
		.cmd(cmd), .st(st), .result_valid(result_valid), .item_kind(item_kind),
		.verdict(verdict), .trail_vertex(trail_vertex), .last(last)
	);

	// Checks
	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !result_valid) else $error("word while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !busy) else $error("busy after last word");
	a_trail_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind |-> verdict == VerdTrail || verdict == VerdCircuit)
		else $error("trail word with reject verdict");
endmodule
`default_nettype wire

>>> bench/tb_euler_trail_finder.sv
// Self-checking bench for euler_trail_finder: edge loads, runs and vertex_count settings.
// Expected words come from a built-in graph predictor; depends on etf_pkg and euler_trail_finder.
`default_nettype none
module tb_euler_trail_finder;
	import etf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic ReqLoad = 1'b0;
	localparam logic ReqRun  = 1'b1;

	typedef struct packed {
		logic            kind;
		logic [1:0]      verd;
		logic [VtxW-1:0] vtx;
		logic            fin;
	} trail_word_t;

	typedef struct packed {
		logic            rtype;
		logic [VtxW-1:0] row;
		logic [VtxW-1:0] col;
		logic            bitv;
	} req_t;

	typedef struct packed {
		req_t       rq;
		logic       has_exp;
		logic [1:0] exp_verd;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [CntW-1:0] cfg_wdata = '0;
	logic req_type = 1'b0;
	logic [VtxW-1:0] row_vertex = '0;
	logic [VtxW-1:0] col_vertex = '0;
	logic edge_bit = 1'b0;
	logic result_valid;
	logic item_kind;
	logic [1:0] verdict;
	logic [VtxW-1:0] trail_vertex;
	logic last;

	// Predictor state
	logic [MaxVertices-1:0] graph_rows [MaxVertices];
	logic [CntW-1:0] vcount_reg;
	trail_word_t pending_words[$];
	int errors = 0;

	// Typed expectation for the next directed row
	logic chk_on = 1'b0;
	logic [1:0] chk_verd = VerdNotConn;

	euler_trail_finder DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_type(req_type), .row_vertex(row_vertex), .col_vertex(col_vertex),
		.edge_bit(edge_bit), .result_valid(result_valid), .item_kind(item_kind),
		.verdict(verdict), .trail_vertex(trail_vertex), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR %s at %0t", what, $realtime);
		errors++;
	endtask

	function automatic trail_word_t mk_word(logic k, logic [1:0] vd, logic [VtxW-1:0] vx,
			logic f);
		trail_word_t w;
		w.kind = k; w.verd = vd; w.vtx = vx; w.fin = f;
		return w;
	endfunction

	// Predict the words of one request and update the graph copy
	task automatic predict_request(input req_t rq);
		int n, odd_cnt, start_v, deg, tp, top, j;
		logic [MaxVertices-1:0] mask, reach, nxt, row;
		logic [1:0] vd;
		int stack_q[$];
		int trail_q[$];
		if (rq.rtype == ReqLoad) begin
			graph_rows[rq.row][rq.col] = rq.bitv;
			graph_rows[rq.col][rq.row] = rq.bitv;
			return;
		end
		n = (vcount_reg == 0) ? 1 : (vcount_reg > MaxVertices ? MaxVertices : vcount_reg);
		mask = (n == MaxVertices) ? '1 : MaxVertices'((1 << n) - 1);
		for (int v = 0; v < n; v++) begin
			if ((graph_rows[v] & mask) == 0) begin
				pending_words.push_back(mk_word(KindVerdict, VerdNotConn, '0, 1'b1));
				return;
			end
		end
		reach = MaxVertices'(1);
		do begin
			nxt = reach;
			for (int v = 0; v < n; v++) if (reach[v]) nxt |= graph_rows[v] & mask;
			row = reach;
			reach = nxt;
		end while (nxt != row);
		if ((reach & mask) != mask) begin
			pending_words.push_back(mk_word(KindVerdict, VerdNotConn, '0, 1'b1));
			return;
		end
		odd_cnt = 0; start_v = 0;
		for (int v = 0; v < n; v++) begin
			deg = 0;
			for (int c = 0; c < MaxVertices; c++)
				if (graph_rows[v][c] && mask[c]) deg += (c == v) ? 2 : 1;
			if (deg % 2) begin
				if (odd_cnt == 0) start_v = v;
				odd_cnt++;
			end
		end
		if (odd_cnt != 0 && odd_cnt != 2) begin
			pending_words.push_back(mk_word(KindVerdict, VerdNotEuler, '0, 1'b1));
			return;
		end
		vd = (odd_cnt == 2) ? VerdTrail : VerdCircuit;
		// Hierholzer walk, lowest neighbor first, consuming edges
		stack_q.push_back(start_v);
		while (stack_q.size() > 0) begin
			top = stack_q[$];
			row = graph_rows[top] & mask;
			if (row != 0) begin
				j = 0;
				while (!row[j]) j++;
				graph_rows[top][j] = 1'b0;
				graph_rows[j][top] = 1'b0;
				stack_q.push_back(j);
			end else begin
				void'(stack_q.pop_back());
				trail_q.push_back(top);
			end
		end
		tp = trail_q.size();
		pending_words.push_back(mk_word(KindVerdict, vd, '0, tp == 0));
		for (int k = 0; k < tp; k++)
			pending_words.push_back(mk_word(KindTrail, vd, VtxW'(trail_q[tp-1-k]), k + 1 == tp));
	endtask

	// Compare each strobed word with the oldest expectation
	always @(posedge clk) begin
		trail_word_t exp_w;
		if (arst_n && result_valid) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word");
			end else begin
				exp_w = pending_words.pop_front();
				if (item_kind !== exp_w.kind) report_mismatch("item_kind");
				if (verdict !== exp_w.verd) report_mismatch("verdict");
				if (trail_vertex !== exp_w.vtx) report_mismatch("trail_vertex");
				if (last !== exp_w.fin) report_mismatch("last");
			end
		end
	end

	function automatic int gap_len();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		return g;
	endfunction

	// Issue one request, hold until accepted; keep start high into a zero gap
	task automatic send_request(input req_t rq);
		int g, base;
		req_type <= rq.rtype;
		row_vertex <= rq.row;
		col_vertex <= rq.col;
		edge_bit <= rq.bitv;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		base = pending_words.size();
		predict_request(rq);
		if (chk_on) begin
			if (pending_words.size() <= base
				|| pending_words[base] != mk_word(KindVerdict, chk_verd, '0, 1'b1))
				report_mismatch("directed expectation");
			chk_on = 1'b0;
		end
		g = gap_len();
		if (g != 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_words();
		start <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_vcount(input logic [CntW-1:0] val);
		drain_words();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		vcount_reg = val;
		@(posedge clk);
	endtask

	function automatic req_t mk_req(logic t, int r, int c, logic b);
		req_t q;
		q.rtype = t; q.row = VtxW'(r); q.col = VtxW'(c); q.bitv = b;
		return q;
	endfunction

	function automatic dir_row_t dr(req_t rq);
		dir_row_t d;
		d.rq = rq; d.has_exp = 1'b0; d.exp_verd = VerdNotConn;
		return d;
	endfunction

	function automatic dir_row_t dr_chk(req_t rq, logic [1:0] vd);
		dir_row_t d;
		d.rq = rq; d.has_exp = 1'b1; d.exp_verd = vd;
		return d;
	endfunction

	// Load a random connected-ish graph over n vertices, sometimes a cycle
	task automatic load_random_graph(input int n);
		int m, a, b;
		for (int v = 0; v < MaxVertices; v++)
			for (int c = v; c < MaxVertices; c++)
				if (graph_rows[v][c]) send_request(mk_req(ReqLoad, v, c, 1'b0));
		if ($urandom_range(0, 1)) begin
			for (int v = 0; v < n; v++) send_request(mk_req(ReqLoad, v, (v + 1) % n, 1'b1));
		end else begin
			for (int v = 1; v < n; v++)
				send_request(mk_req(ReqLoad, v, $urandom_range(0, v - 1), 1'b1));
		end
		m = $urandom_range(0, 3);
		for (int i = 0; i < m; i++) begin
			a = $urandom_range(0, n - 1);
			b = $urandom_range(0, 7);
			send_request(mk_req(ReqLoad, a, b, 1'($urandom_range(0, 1))));
		end
	endtask

	dir_row_t directed_tab [] = '{
		dr_chk(mk_req(ReqRun, 5, 2, 1'b1), VerdNotConn), // empty graph after reset
		dr(mk_req(ReqLoad, 0, 1, 1'b1)),
		dr(mk_req(ReqLoad, 1, 2, 1'b1)),
		dr(mk_req(ReqLoad, 2, 3, 1'b1)),
		dr(mk_req(ReqRun, 0, 0, 1'b0)),                   // path: trail from 0
		dr(mk_req(ReqLoad, 0, 1, 1'b1)),
		dr(mk_req(ReqLoad, 1, 2, 1'b1)),
		dr(mk_req(ReqLoad, 2, 3, 1'b1)),
		dr(mk_req(ReqLoad, 3, 0, 1'b1)),
		dr(mk_req(ReqRun, 7, 7, 1'b1)),                   // square: circuit
		dr(mk_req(ReqLoad, 0, 1, 1'b1)),
		dr(mk_req(ReqLoad, 0, 2, 1'b1)),
		dr(mk_req(ReqLoad, 0, 3, 1'b1)),
		dr_chk(mk_req(ReqRun, 0, 0, 1'b0), VerdNotEuler), // star: four odd vertices
		dr(mk_req(ReqLoad, 1, 1, 1'b1)),                  // self-loops leave degree parity unchanged
		dr(mk_req(ReqLoad, 2, 2, 1'b1)),
		dr(mk_req(ReqLoad, 3, 3, 1'b1)),
		dr(mk_req(ReqLoad, 7, 6, 1'b1)),                  // beyond vertex count: stays stored
		dr(mk_req(ReqLoad, 0, 3, 1'b0)),
		dr(mk_req(ReqRun, 0, 0, 1'b0)),
		dr(mk_req(ReqLoad, 0, 0, 1'b1)),
		dr(mk_req(ReqLoad, 1, 1, 1'b1)),
		dr_chk(mk_req(ReqRun, 0, 0, 1'b0), VerdNotConn)   // two islands
	};

	initial begin
		int n;
		for (int v = 0; v < MaxVertices; v++) graph_rows[v] = '0;
		vcount_reg = CntW'(4);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_tab[i]) begin
			chk_on = directed_tab[i].has_exp;
			chk_verd = directed_tab[i].exp_verd;
			send_request(directed_tab[i].rq);
		end
		// Extremes and out-of-range counts, including zero and saturation
		write_vcount(4'd1);
		send_request(mk_req(ReqRun, 0, 0, 1'b0));
		write_vcount(4'd0);
		send_request(mk_req(ReqRun, 0, 0, 1'b0));
		write_vcount(4'd15);
		load_random_graph(8);
		send_request(mk_req(ReqRun, 0, 0, 1'b0));
		// Random phases over all counts
		for (int ph = 0; ph < 6; ph++) begin
			write_vcount(($urandom_range(0, 5) == 0) ? CntW'($urandom_range(0, 15))
				: CntW'($urandom_range(1, 8)));
			n = (vcount_reg == 0) ? 1 : (vcount_reg > 8 ? 8 : vcount_reg);
			for (int r = 0; r < 3; r++) begin
				load_random_graph(n);
				send_request(mk_req(ReqRun, $urandom_range(0, 7), $urandom_range(0, 7),
					1'($urandom_range(0, 1))));
			end
		end
		write_vcount(4'd4);
		drain_words();
		if (errors == 0) begin
			$display("euler_trail_finder: match");
		end else begin
			$display("euler_trail_finder: mismatch");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("euler_trail_finder: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
